[sv/rth_pkg.sv]
package rth_pkg;

    localparam int unsigned ChanW     = 8;
    localparam int unsigned PixW      = 3 * ChanW;
    localparam int unsigned NumW      = 11;   // k*delta + d, below 6*255
    localparam int unsigned HueRemW   = 19;   // 255 * num
    localparam int unsigned SatRemW   = 16;   // 255 * delta
    localparam int unsigned QuotW     = 8;
    localparam int unsigned NumCells  = QuotW;

    typedef struct packed {
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [ChanW-1:0] brightness;
        logic [ChanW-1:0] saturation;
        logic [ChanW-1:0] hue;
    } t_hsv;

    // one in-flight division pair; divisors are pre-shifted and move right a bit per cell
    typedef struct packed {
        logic [HueRemW-1:0] hue_rem;
        logic [HueRemW-1:0] hue_div;
        logic [QuotW-1:0]   hue_q;
        logic [SatRemW-1:0] sat_rem;
        logic [SatRemW-1:0] sat_div;
        logic [QuotW-1:0]   sat_q;
        logic [ChanW-1:0]   brightness;
    } t_div_data;

endpackage

[sv/rth_front.sv]
module rth_front
    import rth_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_rgb      i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_data o_data
);

    logic             r_valid;
    t_div_data        r_data;
    t_div_data        n_data;
    logic [ChanW-1:0] w_max;
    logic [ChanW-1:0] w_min;
    logic [ChanW-1:0] w_delta;
    logic [NumW-1:0]  w_delta_x;
    logic [NumW-1:0]  w_num;
    logic [HueRemW-1:0] w_hue_dvd;
    logic [HueRemW-1:0] w_hue_dvs;
    logic [SatRemW-1:0] w_sat_dvd;
    logic [SatRemW-1:0] w_sat_dvs;
    logic             w_red_max;
    logic             w_green_max;

    always_comb begin
        w_red_max   = (i_data.red >= i_data.green) && (i_data.red >= i_data.blue);
        w_green_max = !w_red_max && (i_data.green >= i_data.blue);
        if (w_red_max) begin
            w_max = i_data.red;
        end else if (w_green_max) begin
            w_max = i_data.green;
        end else begin
            w_max = i_data.blue;
        end
        w_min = i_data.red;
        if (i_data.green < w_min) begin
            w_min = i_data.green;
        end
        if (i_data.blue < w_min) begin
            w_min = i_data.blue;
        end
        w_delta   = w_max - w_min;
        w_delta_x = NumW'(w_delta);

        if (w_red_max) begin
            if (i_data.green >= i_data.blue) begin
                w_num = NumW'(i_data.green) - NumW'(i_data.blue);
            end else begin
                w_num = (w_delta_x * NumW'(6)) - (NumW'(i_data.blue) - NumW'(i_data.green));
            end
        end else if (w_green_max) begin
            w_num = (w_delta_x << 1) + NumW'(i_data.blue) - NumW'(i_data.red);
        end else begin
            w_num = (w_delta_x << 2) + NumW'(i_data.red) - NumW'(i_data.green);
        end

        // 255*x as (x << 8) - x
        w_hue_dvd = (HueRemW'(w_num) << 8) - HueRemW'(w_num);
        w_sat_dvd = (SatRemW'(w_delta) << 8) - SatRemW'(w_delta);

        // grey or black pixel: zero dividend over a nonzero divisor gives zero
        if (w_delta == '0) begin
            w_hue_dvd = '0;
            w_hue_dvs = HueRemW'(1) << (QuotW - 1);
        end else begin
            w_hue_dvs = (HueRemW'(w_delta_x) * HueRemW'(6)) << (QuotW - 1);
        end
        if (w_max == '0) begin
            w_sat_dvs = SatRemW'(1) << (QuotW - 1);
        end else begin
            w_sat_dvs = SatRemW'(w_max) << (QuotW - 1);
        end

        n_data.hue_rem    = w_hue_dvd;
        n_data.hue_div    = w_hue_dvs;
        n_data.hue_q      = '0;
        n_data.sat_rem    = w_sat_dvd;
        n_data.sat_div    = w_sat_dvs;
        n_data.sat_q      = '0;
        n_data.brightness = w_max;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[sv/rth_div_cell.sv]
module rth_div_cell
    import rth_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_data i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_data o_data
);

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;
    logic      w_hue_bit;
    logic      w_sat_bit;

    // one restoring step for each of the two quotients
    always_comb begin
        n_data    = i_data;
        w_hue_bit = (i_data.hue_rem >= i_data.hue_div);
        w_sat_bit = (i_data.sat_rem >= i_data.sat_div);
        if (w_hue_bit) begin
            n_data.hue_rem = i_data.hue_rem - i_data.hue_div;
        end
        if (w_sat_bit) begin
            n_data.sat_rem = i_data.sat_rem - i_data.sat_div;
        end
        n_data.hue_div = i_data.hue_div >> 1;
        n_data.sat_div = i_data.sat_div >> 1;
        n_data.hue_q   = {i_data.hue_q[QuotW-2:0], w_hue_bit};
        n_data.sat_q   = {i_data.sat_q[QuotW-2:0], w_sat_bit};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[sv/rgb_to_hsv_pixel.sv]
// Pipeline of one registered front stage for max/min/numerator, then one
// registered divider cell per quotient bit, 8 cells, ending at result valid.
// Throughput: one pixel per cycle while not stalled; every stage has its own valid and
// advances into a free slot, so bubbles close up under output stalls.
// Reset: synchronous, active low; clears all stage valid bits, data is not reset.
module rgb_to_hsv_pixel
    import rth_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [PixW-1:0] i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [PixW-1:0] o_m_tdata    // hue[7:0], saturation[15:8], brightness[23:16]
);

    logic      w_valid [NumCells+1];
    logic      w_ready [NumCells+1];
    t_div_data w_data  [NumCells+1];
    t_hsv      w_hsv;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (t_rgb'(i_s_tdata)),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
        rth_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[gi]),
            .o_ready (w_ready[gi]),
            .i_data  (w_data[gi]),
            .o_valid (w_valid[gi+1]),
            .i_ready (w_ready[gi+1]),
            .o_data  (w_data[gi+1])
        );
    end

    assign w_ready[NumCells] = i_m_tready;

    always_comb begin
        w_hsv.hue        = w_data[NumCells].hue_q;
        w_hsv.saturation = w_data[NumCells].sat_q;
        w_hsv.brightness = w_data[NumCells].brightness;
    end

    assign o_m_tvalid = w_valid[NumCells];
    assign o_m_tdata  = w_hsv;

endmodule

[sv/rgb_to_hsv_pixel_checker.sv]
module rgb_to_hsv_pixel_checker
    import rth_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_s_tvalid,
    input logic            o_s_tready,
    input logic [PixW-1:0] i_s_tdata,
    input logic            o_m_tvalid,
    input logic            i_m_tready,
    input logic [PixW-1:0] o_m_tdata
);

    t_hsv w_hsv;
    assign w_hsv = t_hsv'(o_m_tdata);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // an empty output means every stage can advance
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_hsv.hue != 8'hFF)
        else $error("hue out of range");

    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (w_hsv.brightness == '0) |-> (w_hsv.saturation == '0)
            && (w_hsv.hue == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel rgb_to_hsv_pixel_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
